>>> rtl/smpc_pkg.sv
// Shared types, constants and helpers for the shadow memory poison checker.
// Used by the controller, the datapath and the top level; depends on nothing.
package smpc_pkg;

  localparam int ADDR_W  = 15;
  localparam int LEN_W   = 16;
  localparam int TAG_W   = 8;
  localparam int CLASS_W = 3;
  localparam int MODE_W  = 2;
  localparam int CNT_W   = LEN_W - 3;

  localparam int GRANULES_DEF   = 4096;
  localparam int MAX_ACCESS_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POISON = 2'd2;

  localparam logic [TAG_W-1:0] TAG_ADDRESSABLE    = 8'h00;
  localparam logic [TAG_W-1:0] TAG_PARTIAL_MAX    = 8'h07;
  localparam logic [TAG_W-1:0] TAG_GLOBAL_REDZONE = 8'hfa;
  localparam logic [TAG_W-1:0] TAG_HEAP_FREED     = 8'hfd;
  localparam logic [TAG_W-1:0] TAG_HEAP_REDZONE   = 8'hfe;

  localparam logic [CLASS_W-1:0] CLASS_ADDRESSABLE    = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_PARTIAL        = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_GLOBAL_REDZONE = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_HEAP_FREED     = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_HEAP_REDZONE   = 3'd4;
  localparam logic [CLASS_W-1:0] CLASS_UNKNOWN        = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_POISON,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;
    logic load;
    logic rd_en;
    logic eval;
    logic poison_en;
    logic res_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic req_check;
    logic req_poison;
    logic chk_more;
    logic poison_last;
  } status_t;

  function automatic logic [CLASS_W-1:0] classify(input logic [TAG_W-1:0] t);
    logic [CLASS_W-1:0] c;
    if (t == TAG_ADDRESSABLE) c = CLASS_ADDRESSABLE;
    else if (t <= TAG_PARTIAL_MAX) c = CLASS_PARTIAL;
    else if (t == TAG_GLOBAL_REDZONE) c = CLASS_GLOBAL_REDZONE;
    else if (t == TAG_HEAP_FREED) c = CLASS_HEAP_FREED;
    else if (t == TAG_HEAP_REDZONE) c = CLASS_HEAP_REDZONE;
    else c = CLASS_UNKNOWN;
    return c;
  endfunction

endpackage

>>> rtl/smpc_ctrl.sv
// Sequencing state machine of the poison checker: clearing pass, check walk,
// poison fill and result hand-off. Depends on smpc_pkg.
module smpc_ctrl import smpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   res_free;

  assign res_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.req_check) state_d = ST_CHK_RD;
          else if (status_i.req_poison) state_d = ST_POISON;
          else state_d = ST_FINISH;
        end
      end
      ST_CHK_RD: state_d = ST_CHK_EV;
      ST_CHK_EV: begin
        if (!status_i.chk_more) state_d = ST_FINISH;
        else state_d = ST_CHK_RD;
      end
      ST_POISON: begin
        if (status_i.poison_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR:  cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_CHK_RD: cmd_o.rd_en = 1'b1;
      ST_CHK_EV: cmd_o.eval = 1'b1;
      ST_POISON: cmd_o.poison_en = 1'b1;
      ST_FINISH: cmd_o.res_load = res_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.res_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/smpc_datapath.sv
// Datapath of the poison checker: shadow tag memory, walk pointer, range
// compares and the result register. Depends on smpc_pkg.
module smpc_datapath import smpc_pkg::*; #(
  parameter int GRANULES   = GRANULES_DEF,
  parameter int MAX_ACCESS = MAX_ACCESS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic [LEN_W-1:0]   length_i,
  input  logic [TAG_W-1:0]   tag_value_i,
  output logic               poisoned_o,
  output logic               store_echo_o,
  output logic [TAG_W-1:0]   shadow_tag_o,
  output logic [CLASS_W-1:0] tag_class_o,
  output logic               done_res_o
);

  localparam int IW = (GRANULES > 1) ? $clog2(GRANULES) : 1;
  // The pointer must hold the address granule, a poison end under three times the
  // address span and the depth itself.
  localparam int PW = (IW + 2 > 14) ? IW + 2 : 14;
  localparam int BW = PW + 3;
  localparam int SW = $clog2(MAX_ACCESS + 1);
  localparam logic [PW-1:0] DEPTH_P     = PW'(GRANULES);
  localparam logic [BW-1:0] RANGE_BYTES = BW'(GRANULES) << 3;
  localparam logic [IW-1:0] CLR_LAST    = IW'(GRANULES - 1);

  logic [TAG_W-1:0] mem [GRANULES];
  logic [TAG_W-1:0] rdata_q;

  logic [IW-1:0]     clr_cnt_q;
  logic [MODE_W-1:0] mode_q;
  logic [PW-1:0]     ptr_q;
  logic [BW-1:0]     end_q;
  logic              len_nz_q;
  logic              first_q;
  logic              hit_q;
  logic [TAG_W-1:0]  tag_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [2:0]        rem_q;
  logic [TAG_W-1:0]  val_q;

  logic [SW-1:0] len_sat;
  logic [BW-1:0] end_d;
  logic          in_rng;
  logic [BW-1:0] cur;
  logic          hit;
  logic          walk;
  logic          cnt_zero;
  logic          we;
  logic [IW-1:0] waddr;
  logic [TAG_W-1:0] wdata;
  logic          is_check;

  assign len_sat = (length_i > LEN_W'(MAX_ACCESS)) ? SW'(MAX_ACCESS) : length_i[SW-1:0];
  assign end_d   = BW'(address_i) + BW'(len_sat);

  assign in_rng   = ptr_q < DEPTH_P;
  assign cur      = {ptr_q, 3'b000};
  assign walk     = len_nz_q && !hit_q;
  // A granule fails when it lies off the store, carries a poison code, or is
  // partial and the access reaches beyond its addressable bytes.
  assign hit      = !in_rng || ((rdata_q != TAG_ADDRESSABLE) &&
                    ((rdata_q > TAG_PARTIAL_MAX) || (cur + BW'(rdata_q) < end_q)));
  assign cnt_zero = cnt_q == '0;

  assign is_check = (mode_q == MODE_LOAD) || (mode_q == MODE_STORE);

  assign status_o.clr_last    = clr_cnt_q == CLR_LAST;
  assign status_o.req_check   = (mode_i == MODE_LOAD) || (mode_i == MODE_STORE);
  assign status_o.req_poison  = mode_i == MODE_POISON;
  assign status_o.chk_more    = walk && !hit && (cur + BW'(8) < end_q);
  assign status_o.poison_last = cnt_zero || !in_rng;

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q[IW-1:0];
    wdata = val_q;
    if (cmd_i.clr_en) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = TAG_ADDRESSABLE;
    end else if (cmd_i.poison_en && in_rng) begin
      if (!cnt_zero) begin
        we = 1'b1;
      end else if (rem_q != 3'd0) begin
        we    = 1'b1;
        wdata = {{(TAG_W-3){1'b0}}, rem_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.rd_en && in_rng) rdata_q <= mem[ptr_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en && !status_o.clr_last) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      ptr_q    <= {{(PW-(ADDR_W-3)){1'b0}}, address_i[ADDR_W-1:3]};
      end_q    <= end_d;
      len_nz_q <= len_sat != '0;
      first_q  <= 1'b1;
      hit_q    <= (len_sat != '0) && (end_d > RANGE_BYTES);
      tag_q    <= TAG_ADDRESSABLE;
      cnt_q    <= length_i[LEN_W-1:3];
      rem_q    <= length_i[2:0];
      val_q    <= tag_value_i;
    end
    if (cmd_i.eval) begin
      if (first_q) tag_q <= in_rng ? rdata_q : TAG_ADDRESSABLE;
      first_q <= 1'b0;
      if (walk && hit) hit_q <= 1'b1;
      ptr_q <= ptr_q + 1'b1;
    end
    if (cmd_i.poison_en && !cnt_zero) begin
      ptr_q <= ptr_q + 1'b1;
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.res_load) begin
      poisoned_o   <= is_check && hit_q;
      store_echo_o <= mode_q == MODE_STORE;
      shadow_tag_o <= is_check ? tag_q : TAG_ADDRESSABLE;
      tag_class_o  <= is_check ? classify(tag_q) : CLASS_ADDRESSABLE;
      done_res_o   <= mode_q == MODE_POISON;
    end
  end

endmodule

>>> rtl/shadow_memory_poison_checker_core.sv
// Top level of the shadow memory poison checker.
// Instantiates smpc_ctrl and smpc_datapath; depends on smpc_pkg.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) takes one request of mode,
//   address, length and tag_value. The output channel (out_valid_o /
//   out_stall_i) returns exactly one result for every request.
//   One request is worked on at a time; the result sits in an output
//   register, so the next request is taken while an earlier result waits.
//   Work per request:
//     load/store check: one memory read and one compare for each granule
//       touched (1 to 3 at the default access limit), up to the first failing one.
//     poison: the full granules inside the store are written one per cycle
//       through the single write port.
//     unused mode: no memory access.
//   The next request can be taken in the cycle after the result is loaded.
//   After reset the shadow memory is cleared to zero by a pass over all
//   GRANULES entries, one entry a cycle; requests are stalled until it is done.
//   When the receiver stalls, the result holds; a finished request then
//   waits in place until the output register is free.
module shadow_memory_poison_checker_core import smpc_pkg::*; #(
  parameter int GRANULES   = GRANULES_DEF,
  parameter int MAX_ACCESS = MAX_ACCESS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic [LEN_W-1:0]   length_i,
  input  logic [TAG_W-1:0]   tag_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               poisoned_o,
  output logic               store_echo_o,
  output logic [TAG_W-1:0]   shadow_tag_o,
  output logic [CLASS_W-1:0] tag_class_o,
  output logic               done_res_o
);

  cmd_t    cmd;
  status_t status;

  smpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  smpc_datapath #(
    .GRANULES   (GRANULES),
    .MAX_ACCESS (MAX_ACCESS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .mode_i       (mode_i),
    .address_i    (address_i),
    .length_i     (length_i),
    .tag_value_i  (tag_value_i),
    .poisoned_o   (poisoned_o),
    .store_echo_o (store_echo_o),
    .shadow_tag_o (shadow_tag_o),
    .tag_class_o  (tag_class_o),
    .done_res_o   (done_res_o)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for shadow_memory_poison_checker_core: keeps its own copy of the
// shadow store, predicts each result from it and compares every returned field.
// Depends on smpc_pkg and the core RTL only.
module tb;
  import smpc_pkg::*;

  localparam int GRANULES    = GRANULES_DEF;
  localparam int MAX_ACCESS  = MAX_ACCESS_DEF;
  localparam int RANGE_BYTES = GRANULES * 8;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int N_RANDOM     = 1900;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [TAG_W-1:0]  tag_value;
  } request_t;

  typedef struct packed {
    logic               poisoned;
    logic               store_echo;
    logic [TAG_W-1:0]   shadow_tag;
    logic [CLASS_W-1:0] tag_class;
    logic               done_res;
  } verdict_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [MODE_W-1:0]  mode_i      = MODE_LOAD;
  logic [ADDR_W-1:0]  address_i   = '0;
  logic [LEN_W-1:0]   length_i    = '0;
  logic [TAG_W-1:0]   tag_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               poisoned_o;
  logic               store_echo_o;
  logic [TAG_W-1:0]   shadow_tag_o;
  logic [CLASS_W-1:0] tag_class_o;
  logic               done_res_o;

  logic [TAG_W-1:0] shadow_mirror [GRANULES] = '{default: '0};
  request_t         pending_requests [$];
  verdict_t         expected_verdicts [$];

  int unsigned n_total    = 1;
  int unsigned n_accepted = 0;
  int unsigned n_checks   = 0;
  int unsigned n_fills    = 0;
  int unsigned n_unused   = 0;
  int unsigned n_results  = 0;
  int unsigned n_flagged  = 0;
  int unsigned n_mismatch = 0;
  int unsigned cycle_count = 0;

  shadow_memory_poison_checker_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .address_i    (address_i),
    .length_i     (length_i),
    .tag_value_i  (tag_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .poisoned_o   (poisoned_o),
    .store_echo_o (store_echo_o),
    .shadow_tag_o (shadow_tag_o),
    .tag_class_o  (tag_class_o),
    .done_res_o   (done_res_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Applies one request to the mirrored shadow store and returns the result it should give.
  function automatic verdict_t predict_verdict(request_t r);
    verdict_t         v;
    int unsigned      gran, full, span, stop, cur;
    logic [TAG_W-1:0] t;
    v    = '0;
    gran = r.address >> 3;
    if (r.mode == MODE_POISON) begin
      full = r.length >> 3;
      for (int unsigned i = 0; i < full && gran + i < GRANULES; i++)
        shadow_mirror[gran + i] = r.tag_value;
      if (r.length[2:0] != 3'd0 && gran + full < GRANULES)
        shadow_mirror[gran + full] = {5'b0, r.length[2:0]};
      v.done_res = 1'b1;
    end else if (r.mode != MODE_UNUSED) begin
      span         = (r.length > MAX_ACCESS) ? MAX_ACCESS : r.length;
      stop         = r.address + span;
      v.store_echo = (r.mode == MODE_STORE);
      // A 15-bit address always falls inside the 4096 granules covered.
      v.shadow_tag = shadow_mirror[gran];
      case (v.shadow_tag)
        TAG_ADDRESSABLE:    v.tag_class = CLASS_ADDRESSABLE;
        TAG_GLOBAL_REDZONE: v.tag_class = CLASS_GLOBAL_REDZONE;
        TAG_HEAP_FREED:     v.tag_class = CLASS_HEAP_FREED;
        TAG_HEAP_REDZONE:   v.tag_class = CLASS_HEAP_REDZONE;
        default: v.tag_class = (v.shadow_tag <= TAG_PARTIAL_MAX) ? CLASS_PARTIAL : CLASS_UNKNOWN;
      endcase
      if (span != 0 && stop > RANGE_BYTES) begin
        v.poisoned = 1'b1;
      end else if (span != 0) begin
        // A partial tag only allows the leading bytes of its granule.
        for (cur = {r.address[ADDR_W-1:3], 3'b000}; cur < stop; cur += 8) begin
          t = shadow_mirror[cur >> 3];
          if (t > TAG_PARTIAL_MAX || (t != TAG_ADDRESSABLE && cur + t < stop))
            v.poisoned = 1'b1;
        end
      end
    end
    return v;
  endfunction

  function automatic void queue_request(logic [MODE_W-1:0] m, int a, int l, int t);
    request_t r;
    r.mode      = m;
    r.address   = a[ADDR_W-1:0];
    r.length    = l[LEN_W-1:0];
    r.tag_value = t[TAG_W-1:0];
    pending_requests.push_back(r);
  endfunction

  // Idling phases: none, sender idle, receiver stalling, both lightly.
  function automatic int idle_phase();
    int p;
    p = (n_accepted * 4) / n_total;
    return (p > 3) ? 3 : p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : driver_p
    request_t nxt;
    logic     taken;
    int       phase;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      mode_i      <= MODE_LOAD;
      address_i   <= '0;
      length_i    <= '0;
      tag_value_i <= '0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      phase = idle_phase();
      if (taken) begin
        nxt = {mode_i, address_i, length_i, tag_value_i};
        expected_verdicts.push_back(predict_verdict(nxt));
        n_accepted++;
        if (mode_i == MODE_POISON) n_fills++;
        else if (mode_i == MODE_UNUSED) n_unused++;
        else n_checks++;
      end
      if (!in_valid_i || taken) begin
        if (pending_requests.size() > 0 &&
            $urandom_range(99) >= ((phase == 1) ? 58 : (phase == 3) ? 13 : 0)) begin
          nxt = pending_requests.pop_front();
          in_valid_i  <= 1'b1;
          mode_i      <= nxt.mode;
          address_i   <= nxt.address;
          length_i    <= nxt.length;
          tag_value_i <= nxt.tag_value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor_p
    verdict_t got, want;
    int       phase;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      phase = idle_phase();
      if (out_valid_o && !out_stall_i) begin
        got = {poisoned_o, store_echo_o, shadow_tag_o, tag_class_o, done_res_o};
        if (expected_verdicts.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= REPORT_MAX)
            $display("%0t: result with no request outstanding: %h", $realtime, got);
        end else begin
          want = expected_verdicts.pop_front();
          n_results++;
          if (want.poisoned) n_flagged++;
          if (got.poisoned !== want.poisoned || got.store_echo !== want.store_echo ||
              got.shadow_tag !== want.shadow_tag || got.tag_class !== want.tag_class ||
              got.done_res !== want.done_res) begin
            n_mismatch++;
            if (n_mismatch <= REPORT_MAX)
              $display({"%0t: result %0d (expected/got): poisoned %0b/%0b write %0b/%0b ",
                        "tag %02h/%02h class %0d/%0d done %0b/%0b"}, $realtime, n_results,
                       want.poisoned, got.poisoned, want.store_echo, got.store_echo,
                       want.shadow_tag, got.shadow_tag, want.tag_class, got.tag_class,
                       want.done_res, got.done_res);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < ((phase == 2) ? 58 : (phase == 3) ? 13 : 0));
    end
  end

  initial begin : stimulus_p
    int   n_directed, base, size, rz, n, addr, len, region;
    logic timed_out;

    // Directed requests: redzones, partial granules, each tag class and the range edges.
    queue_request(MODE_LOAD, 0, 8, 0);
    queue_request(MODE_POISON, 'h003, 13, TAG_GLOBAL_REDZONE);
    queue_request(MODE_LOAD, 0, 1, 0);
    queue_request(MODE_LOAD, 8, 5, 0);
    queue_request(MODE_STORE, 8, 6, 0);
    queue_request(MODE_LOAD, 12, 0, 0);
    queue_request(MODE_POISON, 'h100, 24, TAG_HEAP_FREED);
    queue_request(MODE_STORE, 'h108, 16, 0);
    queue_request(MODE_POISON, 'h200, 8, TAG_HEAP_REDZONE);
    queue_request(MODE_LOAD, 'h1fc, 'hffff, 'hff);
    queue_request(MODE_POISON, 'h300, 16, 'hff);
    queue_request(MODE_LOAD, 'h300, 1, 0);
    queue_request(MODE_POISON, 'h400, 8, 'h07);
    queue_request(MODE_LOAD, 'h400, 8, 0);
    queue_request(MODE_LOAD, 'h400, 7, 0);
    // A fill that runs off the top end must neither wrap nor write beyond the store.
    queue_request(MODE_POISON, 'h7ff8, 'hffff, 'h99);
    queue_request(MODE_LOAD, 'h7ff8, 8, 0);
    queue_request(MODE_LOAD, 'h7fff, 2, 0);
    queue_request(MODE_UNUSED, 'h7fff, 'hffff, 'hff);
    queue_request(MODE_POISON, 0, 'hffff, TAG_ADDRESSABLE);
    queue_request(MODE_LOAD, 'h7fff, 1, 0);
    queue_request(MODE_STORE, 'h7ff0, 'hffff, 0);
    queue_request(MODE_POISON, 'h7ff8, 0, TAG_HEAP_FREED);
    queue_request(MODE_LOAD, 'h7ff8, 0, 0);
    n_directed = pending_requests.size();

    while (pending_requests.size() < n_directed + N_RANDOM) begin
      if ($urandom_range(99) < 70) begin
        // An object between two redzones, probed around its edges, sometimes freed.
        region = $urandom_range(3);
        if (region == 0) base = $urandom_range(32, 1023);
        else if (region == 1) base = $urandom_range(RANGE_BYTES - 1024, RANGE_BYTES - 8);
        else base = $urandom_range(32, RANGE_BYTES - 8);
        base = base & ~7;
        size = $urandom_range(1, 64);
        rz   = 8 * $urandom_range(1, 3);
        queue_request(MODE_POISON, (base - rz) | $urandom_range(7), rz,
                      $urandom_range(1) ? TAG_GLOBAL_REDZONE : TAG_HEAP_REDZONE);
        queue_request(MODE_POISON, base, size, TAG_ADDRESSABLE);
        queue_request(MODE_POISON, (base + size + 7) & ~7, rz,
                      $urandom_range(1) ? TAG_GLOBAL_REDZONE : TAG_HEAP_REDZONE);
        if ($urandom_range(3) == 0)
          queue_request(MODE_POISON, base, (size + 7) & ~7, TAG_HEAP_FREED);
        n = $urandom_range(2, 8);
        for (int i = 0; i < n; i++) begin
          addr = base - rz + $urandom_range(0, size + 2 * rz);
          len  = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(0, 17);
          queue_request($urandom_range(1) ? MODE_STORE : MODE_LOAD, addr, len,
                        $urandom_range(255));
        end
      end else begin
        // Unstructured noise over every mode; long fills are kept rare as they are slow.
        addr = $urandom_range(RANGE_BYTES - 1);
        if ($urandom_range(3) == 2) begin
          len = ($urandom_range(99) == 0) ? $urandom_range(65535) : $urandom_range(200);
          queue_request(MODE_POISON, addr, len, $urandom_range(255));
        end else begin
          len = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(24);
          queue_request(MODE_W'($urandom_range(3)), addr, len, $urandom_range(255));
        end
      end
    end
    n_total = pending_requests.size();

    while (!(pending_requests.size() == 0 && !in_valid_i && expected_verdicts.size() == 0)
           && cycle_count < CYCLE_LIMIT)
      @(posedge clk_i);
    timed_out = (cycle_count >= CYCLE_LIMIT);
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (timed_out) $display("Run stopped at the cycle limit of %0d.", CYCLE_LIMIT);
    n_mismatch += expected_verdicts.size();

    $display("Sent %0d requests: %0d load/store checks, %0d poison fills, %0d unused mode.",
             n_accepted, n_checks, n_fills, n_unused);
    $display("Compared %0d results, %0d of them flagged as poisoned; %0d mismatches.",
             n_results, n_flagged, n_mismatch);
    if (!timed_out && n_mismatch == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
